FILE: hdl/ptac_pkg.sv
// Shared types, constants and helper functions for the pattern table adjacency counter.
`default_nettype none
package ptac_pkg;

  // Fixed field widths and table sizes.
  localparam int MAX_PATTERNS = 64;
  localparam int ID_W         = 6;
  localparam int MAX_WIDTH    = 256;
  localparam int COL_W        = 8;
  localparam int ROW_W        = 16;
  localparam int GW_W         = 9;
  localparam int COUNT_BITS   = 16;
  localparam int HASH_W       = 64;
  localparam int TOTAL_W      = 7;
  localparam int DIR_W        = 2;
  localparam int MARK_W       = 4;
  localparam int ADJ_AW       = ID_W + DIR_W + ID_W;
  localparam int FM_W         = COUNT_BITS + MARK_W;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  typedef logic [DIR_W-1:0] dir_t;

  localparam dir_t DIR_UP    = 2'd0;
  localparam dir_t DIR_DOWN  = 2'd1;
  localparam dir_t DIR_LEFT  = 2'd2;
  localparam dir_t DIR_RIGHT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  // Access request to the adjacency count memory.
  typedef struct packed {
    logic                  rd_en;
    logic [ADJ_AW-1:0]     raddr;
    logic                  wr_en;
    logic [ADJ_AW-1:0]     waddr;
    logic [COUNT_BITS-1:0] wdata;
  } adj_req_t;

  // Address of one (id, direction, neighbour) counter.
  function automatic logic [ADJ_AW-1:0] adj_addr(logic [ID_W-1:0] id, dir_t d,
                                                 logic [ID_W-1:0] nb);
    return {id, d, nb};
  endfunction

  // Saturating increment of a counter.
  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/ptac_in_if.sv
// Request channel carrying grid cells and statistics reads.
`default_nettype none
interface ptac_in_if import ptac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [HASH_W-1:0] cell_hash;
  logic [ID_W-1:0]  query_pattern;
  logic [DIR_W-1:0] query_direction;
  logic [ID_W-1:0]  query_neighbour;

  modport source(output valid, mode, cell_hash, query_pattern, query_direction,
                 query_neighbour, input ready);
  modport sink(input valid, mode, cell_hash, query_pattern, query_direction,
               query_neighbour, output ready);
endinterface
`default_nettype wire

FILE: hdl/ptac_out_if.sv
// Result channel carrying one result per request.
`default_nettype none
interface ptac_out_if import ptac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ID_W-1:0]       cell_id;
  logic                  is_new;
  logic                  table_full;
  logic [COUNT_BITS-1:0] frequency;
  logic [COUNT_BITS-1:0] adjacency_count;
  logic                  at_boundary;
  logic [TOTAL_W-1:0]    pattern_total;

  modport source(output valid, cell_id, is_new, table_full, frequency, adjacency_count,
                 at_boundary, pattern_total, input ready);
  modport sink(input valid, cell_id, is_new, table_full, frequency, adjacency_count,
               at_boundary, pattern_total, output ready);
endinterface
`default_nettype wire

FILE: hdl/ptac_adj_store.sv
// Adjacency count memory with a clearing sweep after reset.
`default_nettype none
module ptac_adj_store import ptac_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire adj_req_t              req,
  output logic [COUNT_BITS-1:0]      rdata,
  output logic                       busy
);

  logic [COUNT_BITS-1:0] mem [1 << ADJ_AW];
  logic                  clr_r;
  logic [ADJ_AW-1:0]     clr_addr_r;
  logic [COUNT_BITS-1:0] rdata_r;

  // Clearing sweep, one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == {ADJ_AW{1'b1}}) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Single write port and registered read port.
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_r;

endmodule
`default_nettype wire

FILE: hdl/pattern_table_adjacency_counter_core.sv
// Top level: pattern table, frequency, boundary and adjacency statistics.
//
// Channels: in_ch takes one request per handshake. Mode 0 is the next grid
// cell in raster order with its pattern hash; mode 1 reads the frequency,
// boundary mark and one adjacency count of a pattern id. out_ch returns one
// result per request, in order. The cfg_ port writes grid_width (index 0) and
// grid_height (index 1); the user must write only while the block is idle (not enforced).
// Timing: requests are handled one at a time. A read passes through the QRY
// and DONE states. A grid cell scans the hash entries (one per cycle, up to
// the number of distinct patterns plus one), then reads and writes its
// frequency and marks, advances the position and counts p neighbour pairs
// (0, 2 or 4), each a read-modify-write on the single adjacency memory
// port, before DONE. A cell that finds the table full skips the frequency
// update and the pair counts. Reset: all statistics read as zero. Every
// entry of the adjacency memory is swept clear after reset; in_ch.ready
// stays low during the sweep while configuration writes are still taken.
// Stalls: a result waits in the output register until out_ch.ready; the
// next request is not accepted until the finished one has moved into that register.
`default_nettype none
module pattern_table_adjacency_counter_core import ptac_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ptac_in_if.sink                    in_ch,
  ptac_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_SEARCH = 10'b0000000100,
    ST_FRD    = 10'b0000001000,
    ST_FWR    = 10'b0000010000,
    ST_POS    = 10'b0000100000,
    ST_ARD    = 10'b0001000000,
    ST_AWR    = 10'b0010000000,
    ST_QRY    = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [GW_W-1:0]      gw_r;
  logic [ROW_W-1:0]     gh_r;
  logic [COL_W-1:0]     col_r;
  logic [ROW_W-1:0]     row_r;
  logic [ID_W-1:0]      prev_id_r;
  logic                 prev_vld_r;
  logic [MAX_WIDTH-1:0] line_vld_r;
  logic [TOTAL_W-1:0]   dist_r;

  // Snapshot of the cell being processed.
  logic [HASH_W-1:0]    hash_r;
  logic [DIR_W-1:0]     qd_r;
  logic [COL_W-1:0]     c_col_r;
  logic                 c_first_r, c_last_row_r, c_last_col_r;
  logic [ID_W-1:0]      c_prev_r;
  logic                 c_prev_ok_r, c_above_ok_r;
  logic [TOTAL_W-1:0]   scan_r;
  logic [ID_W-1:0]      id_r;
  logic                 has_r, new_r, full_r;
  logic [3:0]           pend_r, cur_bit_r;
  logic [ADJ_AW-1:0]    cur_addr_r;

  // Result holding and output registers.
  logic [ID_W-1:0]       res_id_r, out_id_r;
  logic                  res_new_r, out_new_r, res_full_r, out_full_r;
  logic [COUNT_BITS-1:0] res_freq_r, out_freq_r, res_adj_r, out_adj_r;
  logic                  res_bnd_r, out_bnd_r;
  logic [TOTAL_W-1:0]    res_total_r, out_total_r;
  logic                  out_vld_r;

  // Memories.
  logic [HASH_W-1:0] hash_mem [MAX_PATTERNS];
  logic [FM_W-1:0]   fm_mem [MAX_PATTERNS];
  logic [ID_W-1:0]   line_mem [MAX_WIDTH];
  logic [MAX_PATTERNS-1:0] fm_vld_r;
  logic [HASH_W-1:0] hash_q;
  logic [FM_W-1:0]   fm_q;
  logic              fm_vq_r;
  logic [ID_W-1:0]   line_q;

  logic                  accept;
  logic [ID_W-1:0]       hash_raddr, fm_raddr;
  logic [GW_W-1:0]       eff_w;
  logic [ROW_W-1:0]      eff_h;
  logic                  last_col, last_row;
  logic                  found, miss;
  logic [FM_W-1:0]       fm_old;
  logic [MARK_W-1:0]     mark_set;
  logic [ADJ_AW-1:0]     sel_addr;
  logic [3:0]            sel_bit;
  logic [3:0]            pend_left;
  adj_req_t              adj_req;
  logic [COUNT_BITS-1:0] adj_q;
  logic                  adj_busy;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // Effective grid size and edge flags of the current position.
  always_comb begin
    eff_w = (gw_r == '0) ? GW_W'(1) : gw_r;
    if (eff_w > GW_W'(MAX_WIDTH)) begin
      eff_w = GW_W'(MAX_WIDTH);
    end
    eff_h    = (gh_r == '0) ? ROW_W'(1) : gh_r;
    last_col = ({1'b0, col_r} + GW_W'(1)) >= eff_w;
    last_row = ({1'b0, row_r} + (ROW_W + 1)'(1)) >= {1'b0, eff_h};
  end

  // Hash scan compare: the entry under scan_r is in hash_q.
  assign miss  = (scan_r == dist_r);
  assign found = !miss && (hash_q == hash_r);

  assign hash_raddr = (state_r == ST_IDLE) ? '0 : ID_W'(scan_r + 1'b1);
  assign fm_raddr   = (state_r == ST_IDLE) ? in_ch.query_pattern : id_r;

  // Old frequency and marks, and the marks this cell sets.
  always_comb begin
    fm_old   = fm_vq_r ? fm_q : '0;
    mark_set = '0;
    mark_set[DIR_UP]   = c_first_r;
    mark_set[DIR_DOWN] = c_last_row_r;
    if (!c_first_r && !c_last_row_r) begin
      mark_set[DIR_LEFT]  = (c_col_r == '0);
      mark_set[DIR_RIGHT] = c_last_col_r;
    end
  end

  // First pending neighbour pair.
  always_comb begin
    sel_addr = adj_addr(line_q, DIR_UP, id_r);
    sel_bit  = 4'b1000;
    if (pend_r[0]) begin
      sel_addr = adj_addr(c_prev_r, DIR_RIGHT, id_r);
      sel_bit  = 4'b0001;
    end else if (pend_r[1]) begin
      sel_addr = adj_addr(id_r, DIR_LEFT, c_prev_r);
      sel_bit  = 4'b0010;
    end else if (pend_r[2]) begin
      sel_addr = adj_addr(id_r, DIR_DOWN, line_q);
      sel_bit  = 4'b0100;
    end
    pend_left = pend_r & ~cur_bit_r;
  end

  // Adjacency memory access.
  always_comb begin
    adj_req       = '0;
    adj_req.wdata = sat_inc(adj_q);
    adj_req.waddr = cur_addr_r;
    adj_req.wr_en = (state_r == ST_AWR);
    if (state_r == ST_ARD) begin
      adj_req.rd_en = 1'b1;
      adj_req.raddr = sel_addr;
    end else if (accept && in_ch.mode) begin
      adj_req.rd_en = 1'b1;
      adj_req.raddr = adj_addr(in_ch.query_pattern, in_ch.query_direction,
                               in_ch.query_neighbour);
    end
  end

  ptac_adj_store u_adj (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (adj_req),
    .rdata (adj_q),
    .busy  (adj_busy)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (!adj_busy) state_nxt = ST_IDLE;
      ST_IDLE:   if (accept) state_nxt = in_ch.mode ? ST_QRY : ST_SEARCH;
      ST_SEARCH: begin
        if (found || (miss && dist_r != TOTAL_W'(MAX_PATTERNS))) begin
          state_nxt = ST_FRD;
        end else if (miss) begin
          state_nxt = ST_POS;
        end
      end
      ST_FRD:    state_nxt = ST_FWR;
      ST_FWR:    state_nxt = ST_POS;
      ST_POS:    state_nxt = (has_r && (c_prev_ok_r || c_above_ok_r)) ? ST_ARD : ST_DONE;
      ST_ARD:    state_nxt = ST_AWR;
      ST_AWR:    state_nxt = (pend_left != '0) ? ST_ARD : ST_DONE;
      ST_QRY:    state_nxt = ST_DONE;
      ST_DONE:   if (!out_vld_r || out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      gw_r       <= GW_W'(16);
      gh_r       <= ROW_W'(16);
      col_r      <= '0;
      row_r      <= '0;
      prev_id_r  <= '0;
      prev_vld_r <= 1'b0;
      line_vld_r <= '0;
      dist_r     <= '0;
      fm_vld_r   <= '0;
      pend_r     <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  gw_r <= cfg_data[GW_W-1:0];
          CFG_GRID_HEIGHT: gh_r <= cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_SEARCH && miss && dist_r != TOTAL_W'(MAX_PATTERNS)) begin
        dist_r <= dist_r + 1'b1;
      end
      if (state_r == ST_FWR) begin
        fm_vld_r[id_r] <= 1'b1;
      end
      // Position advance and neighbour bookkeeping.
      if (state_r == ST_POS) begin
        line_vld_r[c_col_r] <= has_r;
        prev_id_r  <= id_r;
        prev_vld_r <= has_r && !c_last_col_r;
        if (c_last_col_r) begin
          col_r <= '0;
          row_r <= c_last_row_r ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
        pend_r <= {c_above_ok_r, c_above_ok_r, c_prev_ok_r, c_prev_ok_r} & {4{has_r}};
      end else if (state_r == ST_AWR) begin
        pend_r <= pend_left;
      end
      if (state_r == ST_DONE && (!out_vld_r || out_ch.ready)) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Request snapshot, scan and results.
  always_ff @(posedge clk) begin
    if (accept) begin
      hash_r       <= in_ch.cell_hash;
      qd_r         <= in_ch.query_direction;
      c_col_r      <= col_r;
      c_first_r    <= (row_r == '0);
      c_last_row_r <= last_row;
      c_last_col_r <= last_col;
      c_prev_r     <= prev_id_r;
      c_prev_ok_r  <= (col_r != '0) && prev_vld_r;
      c_above_ok_r <= (row_r != '0) && line_vld_r[col_r];
      scan_r       <= '0;
      id_r         <= '0;
      has_r        <= 1'b0;
      new_r        <= 1'b0;
      full_r       <= 1'b0;
    end
    if (state_r == ST_SEARCH) begin
      if (found) begin
        id_r  <= scan_r[ID_W-1:0];
        has_r <= 1'b1;
      end else if (miss) begin
        if (dist_r != TOTAL_W'(MAX_PATTERNS)) begin
          id_r   <= dist_r[ID_W-1:0];
          has_r  <= 1'b1;
          new_r  <= 1'b1;
        end else begin
          full_r <= 1'b1;
        end
      end else begin
        scan_r <= scan_r + 1'b1;
      end
    end
    if (state_r == ST_ARD) begin
      cur_addr_r <= sel_addr;
      cur_bit_r  <= sel_bit;
    end
    if (state_r == ST_POS) begin
      res_id_r    <= id_r;
      res_new_r   <= new_r;
      res_full_r  <= full_r;
      res_freq_r  <= '0;
      res_adj_r   <= '0;
      res_bnd_r   <= 1'b0;
      res_total_r <= dist_r;
    end
    if (state_r == ST_QRY) begin
      res_id_r    <= '0;
      res_new_r   <= 1'b0;
      res_full_r  <= 1'b0;
      res_freq_r  <= fm_old[FM_W-1:MARK_W];
      res_adj_r   <= adj_q;
      res_bnd_r   <= fm_old[qd_r];
      res_total_r <= dist_r;
    end
    if (state_r == ST_DONE && (!out_vld_r || out_ch.ready)) begin
      out_id_r    <= res_id_r;
      out_new_r   <= res_new_r;
      out_full_r  <= res_full_r;
      out_freq_r  <= res_freq_r;
      out_adj_r   <= res_adj_r;
      out_bnd_r   <= res_bnd_r;
      out_total_r <= res_total_r;
    end
  end

  // Hash table memory.
  always_ff @(posedge clk) begin
    if (state_r == ST_SEARCH && miss && dist_r != TOTAL_W'(MAX_PATTERNS)) begin
      hash_mem[dist_r[ID_W-1:0]] <= hash_r;
    end
    hash_q <= hash_mem[hash_raddr];
  end

  // Frequency and boundary mark memory.
  always_ff @(posedge clk) begin
    if (state_r == ST_FWR) begin
      fm_mem[id_r] <= {sat_inc(fm_old[FM_W-1:MARK_W]), fm_old[MARK_W-1:0] | mark_set};
    end
    fm_q    <= fm_mem[fm_raddr];
    fm_vq_r <= fm_vld_r[fm_raddr];
  end

  // Line store of the previous row's ids.
  always_ff @(posedge clk) begin
    if (state_r == ST_POS) begin
      line_mem[c_col_r] <= id_r;
    end
    if (accept) begin
      line_q <= line_mem[col_r];
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.cell_id         = out_id_r;
  assign out_ch.is_new          = out_new_r;
  assign out_ch.table_full      = out_full_r;
  assign out_ch.frequency       = out_freq_r;
  assign out_ch.adjacency_count = out_adj_r;
  assign out_ch.at_boundary     = out_bnd_r;
  assign out_ch.pattern_total   = out_total_r;

  // The table never holds more ids than it has entries.
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dist_r <= TOTAL_W'(MAX_PATTERNS))
    else $error("distinct count beyond table size");

  // No request is taken while the adjacency memory is being cleared.
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    adj_busy |-> !in_ch.ready)
    else $error("request accepted during clearing sweep");

  // An accepted request always moves the sequencer out of idle.
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("sequencer stayed idle after a request");

  // A new id is only given while the table has room.
  a_new_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH && miss && dist_r == TOTAL_W'(MAX_PATTERNS)) |=> !has_r)
    else $error("id given with the table full");

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the pattern table adjacency counter core.
`default_nettype none
module tb_top import ptac_pkg::*; ();

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ptac_in_if in_ch ();
  ptac_out_if out_ch ();

  pattern_table_adjacency_counter_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock with a 10 unit period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic             mode;
    logic [HASH_W-1:0] hash;
    logic [ID_W-1:0]  qp;
    dir_t             qd;
    logic [ID_W-1:0]  qn;
  } cell_req_t;

  typedef struct packed {
    logic [ID_W-1:0]       cell_id;
    logic                  is_new;
    logic                  table_full;
    logic [COUNT_BITS-1:0] frequency;
    logic [COUNT_BITS-1:0] adjacency_count;
    logic                  at_boundary;
    logic [TOTAL_W-1:0]    pattern_total;
  } stat_res_t;

  // Shadow copy of the block's statistics and grid position.
  logic [HASH_W-1:0]     known_hash [MAX_PATTERNS];
  int unsigned           n_distinct;
  logic [COUNT_BITS-1:0] freq_tab [MAX_PATTERNS];
  logic [MARK_W-1:0]     mark_tab [MAX_PATTERNS];
  logic [COUNT_BITS-1:0] pair_tab [MAX_PATTERNS*4*MAX_PATTERNS];
  logic [ID_W-1:0]       row_ids [MAX_WIDTH];
  bit                    row_ok [MAX_WIDTH];
  logic [ID_W-1:0]       left_id;
  bit                    left_ok;
  int unsigned           cur_col, cur_row;
  logic [GW_W-1:0]       width_reg;
  logic [ROW_W-1:0]      height_reg;

  stat_res_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int n_results = 0;
  int n_new = 0, n_full = 0, n_reads = 0;
  bit idle_off = 1'b0;
  localparam int LIMIT = 3000000;

  function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic int pidx(int unsigned id, dir_t d, int unsigned nb);
    return (id * 4 + d) * MAX_PATTERNS + nb;
  endfunction

  task automatic clear_stats();
    n_distinct = 0;
    for (int i = 0; i < MAX_PATTERNS; i++) begin
      freq_tab[i] = '0;
      mark_tab[i] = '0;
      known_hash[i] = '0;
    end
    foreach (pair_tab[i]) pair_tab[i] = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_ids[i] = '0;
      row_ok[i] = 1'b0;
    end
    left_id = '0;
    left_ok = 1'b0;
    cur_col = 0;
    cur_row = 0;
    width_reg = 9'd16;
    height_reg = 16'd16;
  endtask

  // Predict one result and update the shadow statistics.
  function automatic stat_res_t predict_stats(cell_req_t r);
    stat_res_t o;
    int unsigned ew, eh, col, id;
    bit last_col, last_row, first_row, has_id;
    o = '0;
    if (r.mode) begin
      o.frequency = freq_tab[r.qp];
      o.adjacency_count = pair_tab[pidx(r.qp, r.qd, r.qn)];
      o.at_boundary = mark_tab[r.qp][r.qd];
      o.pattern_total = n_distinct[TOTAL_W-1:0];
      return o;
    end
    ew = (width_reg == 0) ? 1 : width_reg;
    eh = (height_reg == 0) ? 1 : height_reg;
    if (ew > MAX_WIDTH) ew = MAX_WIDTH;
    col = cur_col % MAX_WIDTH;
    last_col = (col + 1 >= ew);
    last_row = (cur_row + 1 >= eh);
    first_row = (cur_row == 0);
    has_id = 1'b0;
    id = 0;
    for (int i = 0; i < n_distinct; i++) begin
      if (!has_id && known_hash[i] == r.hash) begin
        id = i;
        has_id = 1'b1;
      end
    end
    if (!has_id) begin
      if (n_distinct < MAX_PATTERNS) begin
        id = n_distinct;
        known_hash[id] = r.hash;
        n_distinct++;
        has_id = 1'b1;
        o.is_new = 1'b1;
      end else begin
        o.table_full = 1'b1;
      end
    end
    if (has_id) begin
      freq_tab[id] = bump(freq_tab[id]);
      if (first_row) mark_tab[id][DIR_UP] = 1'b1;
      if (last_row) mark_tab[id][DIR_DOWN] = 1'b1;
      if (!first_row && !last_row) begin
        if (col == 0) mark_tab[id][DIR_LEFT] = 1'b1;
        if (last_col) mark_tab[id][DIR_RIGHT] = 1'b1;
      end
      if (col > 0 && left_ok) begin
        pair_tab[pidx(left_id, DIR_RIGHT, id)] = bump(pair_tab[pidx(left_id, DIR_RIGHT, id)]);
        pair_tab[pidx(id, DIR_LEFT, left_id)] = bump(pair_tab[pidx(id, DIR_LEFT, left_id)]);
      end
      if (!first_row && row_ok[col]) begin
        pair_tab[pidx(id, DIR_DOWN, row_ids[col])] =
          bump(pair_tab[pidx(id, DIR_DOWN, row_ids[col])]);
        pair_tab[pidx(row_ids[col], DIR_UP, id)] =
          bump(pair_tab[pidx(row_ids[col], DIR_UP, id)]);
      end
      o.cell_id = id[ID_W-1:0];
    end
    row_ids[col] = id[ID_W-1:0];
    row_ok[col] = has_id;
    left_id = id[ID_W-1:0];
    left_ok = has_id;
    if (last_col) begin
      cur_col = 0;
      left_ok = 1'b0;
      cur_row = last_row ? 0 : ((cur_row + 1) & 16'hFFFF);
    end else begin
      cur_col = col + 1;
    end
    o.pattern_total = n_distinct[TOTAL_W-1:0];
    return o;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout at %0t", $time);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      stat_res_t got, exp_r;
      got = '{out_ch.cell_id, out_ch.is_new, out_ch.table_full, out_ch.frequency,
              out_ch.adjacency_count, out_ch.at_boundary, out_ch.pattern_total};
      n_results++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got.cell_id !== exp_r.cell_id ||
            got.is_new !== exp_r.is_new ||
            got.table_full !== exp_r.table_full ||
            got.frequency !== exp_r.frequency ||
            got.adjacency_count !== exp_r.adjacency_count ||
            got.at_boundary !== exp_r.at_boundary ||
            got.pattern_total !== exp_r.pattern_total) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
        end
      end
    end
  end

  // Receiver stalls in random bursts.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!idle_off && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Send one request; the expectation is recorded on acceptance.
  task automatic send_request(cell_req_t r, bit has_typed, stat_res_t typed);
    stat_res_t p;
    if (!idle_off && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= r.mode;
    in_ch.cell_hash <= r.hash;
    in_ch.query_pattern <= r.qp;
    in_ch.query_direction <= r.qd;
    in_ch.query_neighbour <= r.qn;
    // Ready only moves at a rising edge, so its value here holds until the next one.
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    p = predict_stats(r);
    if (r.mode) n_reads++;
    if (p.is_new) n_new++;
    if (p.table_full) n_full++;
    expected_results.insert(expected_results.size(), has_typed ? typed : p);
    if (has_typed && typed !== p)
      $display("%0t: note, table row differs from predictor", $time);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_GRID_WIDTH) width_reg = val[GW_W-1:0];
    else height_reg = val;
  endtask

  // Hash from a small pool so that patterns repeat.
  function automatic logic [HASH_W-1:0] pool_hash(int unsigned k);
    return {32'hA5C3_0000 ^ k, 32'h0000_1000 + k};
  endfunction

  cell_req_t dir_rows [16];
  stat_res_t dir_exp [16];
  bit        dir_has [16];

  initial begin
    cell_req_t r;
    stat_res_t z;
    int pool;
    int widths [5] = '{2, 3, 7, 256, 300};
    int heights [5] = '{2, 5, 3, 2, 1};
    clear_stats();
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.cell_hash = '0;
    in_ch.query_pattern = '0;
    in_ch.query_direction = DIR_UP;
    in_ch.query_neighbour = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed table: reads after reset, extreme hashes and ids, all directions.
    z = '0;
    dir_rows[0] = '{1'b1, '0, 6'd0, DIR_UP, 6'd0};     dir_has[0] = 1; dir_exp[0] = z;
    dir_rows[1] = '{1'b1, '1, 6'd63, DIR_RIGHT, 6'd63}; dir_has[1] = 1; dir_exp[1] = z;
    dir_rows[2] = '{1'b0, '0, 6'd0, DIR_UP, 6'd0};     dir_has[2] = 1;
    dir_exp[2] = '{6'd0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0, 7'd1};
    dir_rows[3] = '{1'b0, '1, 6'd0, DIR_UP, 6'd0};     dir_has[3] = 1;
    dir_exp[3] = '{6'd1, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0, 7'd2};
    dir_rows[4] = '{1'b0, '0, 6'd63, DIR_DOWN, 6'd63}; dir_has[4] = 1;
    dir_exp[4] = '{6'd0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 7'd2};
    for (int i = 5; i < 16; i++) begin
      dir_has[i] = 0;
      dir_exp[i] = z;
      dir_rows[i] = '{1'b1, 64'h8000_0000_0000_0001, 6'(i % 3), dir_t'(i % 4), 6'(i % 2)};
    end
    dir_rows[15].mode = 1'b0;
    dir_rows[14].mode = 1'b0;
    for (int i = 0; i < 16; i++) send_request(dir_rows[i], dir_has[i], dir_exp[i]);
    drain_results();

    // Random phases over several grid shapes, including zero-size registers.
    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 5) begin
        write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(widths[ph]));
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(heights[ph]));
      end else if (ph == 5) begin
        write_reg(CFG_GRID_WIDTH, 16'd0);
        write_reg(CFG_GRID_HEIGHT, 16'd0);
      end else begin
        write_reg(CFG_GRID_WIDTH, 16'h01FF);
        write_reg(CFG_GRID_HEIGHT, 16'hFFFF);
        idle_off = 1'b1;
      end
      pool = (ph < 3) ? 12 : 90;
      for (int n = 0; n < 100; n++) begin
        r.mode = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0)
          r.hash = {$urandom, $urandom};
        else
          r.hash = pool_hash($urandom_range(0, pool - 1));
        r.qp = ID_W'($urandom_range(0, (n_distinct > 0 && $urandom_range(0, 5) != 0)
                                       ? n_distinct - 1 : 63));
        r.qd = dir_t'($urandom_range(0, 3));
        r.qn = ID_W'($urandom_range(0, (n_distinct > 0 && $urandom_range(0, 5) != 0)
                                       ? n_distinct - 1 : 63));
        send_request(r, 1'b0, z);
        if (n == 50) drain_results();
      end
      drain_results();
    end

    $display("Covered %0d results: %0d new ids, %0d table-full cells, %0d reads,",
             n_results, n_new, n_full, n_reads);
    $display("over seven grid shapes from degenerate to maximum size.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
